// ===== design/svna_pkg.sv =====
// ----------------------------------------------------------------------------
// svna_pkg: shared types and constants
// Table sizing, field widths, status codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package svna_pkg;

  localparam int TABLE_ENTRIES = 1024;
  localparam int AW            = $clog2(TABLE_ENTRIES);
  localparam int CW            = $clog2(TABLE_ENTRIES + 1);

  localparam int CRD_W = 16;
  localparam int KEY_W = 3 * CRD_W;
  localparam int SUM_W = 48;
  localparam int NRM_W = 16;
  localparam int R_W   = 17;
  localparam int SQ_W  = 34;
  localparam int S_W   = 36;
  localparam int DQ_W  = 62;
  localparam int OP_W  = 30;
  localparam int CNT_W = 6;

  localparam logic [CNT_W-1:0] XP_LAST   = 6'd6;
  localparam logic [CNT_W-1:0] SQ_LAST   = 6'd3;
  localparam logic [CNT_W-1:0] DIV_LAST  = 6'd61;
  localparam logic [CNT_W-1:0] SQRT_LAST = 6'd14;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_FULL = 2'd2,
    ST_MISS = 2'd3
  } status_t;

  typedef enum logic {
    FN_ADD   = 1'b0,
    FN_QUERY = 1'b1
  } func_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SCAN,
    S_CHECK,
    S_XP,
    S_NINIT,
    S_NSHIFT,
    S_NSQ,
    S_DLOAD,
    S_DIV,
    S_SLOAD,
    S_SQRT,
    S_NSTORE,
    S_ADDV,
    S_ACC_RD,
    S_ACC_WR,
    S_Q_RD,
    S_Q_WR,
    S_FIN
  } state_t;

  typedef struct packed {
    logic    load;
    logic    scan;
    logic    xp;
    logic    ninit;
    logic    shift;
    logic    sq;
    logic    dload;
    logic    div;
    logic    sload;
    logic    sqrt;
    logic    nstore;
    logic    addv;
    logic    acc_rd;
    logic    acc_wr;
    logic    q_wr;
    logic    cnt_clr;
    logic    res_ld;
    status_t code;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic is_query;
    logic fnd0;
    logic full;
    logic xp_done;
    logic big;
    logic zero;
    logic sq_done;
    logic div_done;
    logic sqrt_done;
    logic comp_last;
    logic cur_fnd;
    logic vtx_last;
    logic out_room;
  } sts_t;

endpackage

// ===== design/svna_ram.sv =====
// ----------------------------------------------------------------------------
// svna_ram: generic single-port-write RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module svna_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/svna_ctrl.sv =====
// ----------------------------------------------------------------------------
// svna_ctrl: sequencing state machine
// Steps one item through search, cross product or stored-sum read, normalise and accumulate.
// ----------------------------------------------------------------------------
module svna_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  svna_pkg::sts_t    sts,
  output svna_pkg::cmd_t    cmd
);

  import svna_pkg::*;

  state_t  state_r, state_nxt;
  status_t code_r, code_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      code_r  <= ST_OK;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_SCAN;
      S_SCAN:   if (sts.scan_done) state_nxt = S_CHECK;
      S_CHECK: begin
        if (sts.is_query) begin
          if (!sts.fnd0) begin
            state_nxt = S_FIN;
            code_nxt  = ST_MISS;
          end else begin
            state_nxt = S_Q_RD;
          end
        end else if (sts.full) begin
          state_nxt = S_FIN;
          code_nxt  = ST_FULL;
        end else begin
          state_nxt = S_XP;
        end
      end
      S_XP:     if (sts.xp_done) state_nxt = S_NINIT;
      S_NINIT:  state_nxt = S_NSHIFT;
      S_NSHIFT: begin
        if (!sts.big) begin
          if (!sts.zero) begin
            state_nxt = S_NSQ;
          end else if (sts.is_query) begin
            state_nxt = S_FIN;
            code_nxt  = ST_ZERO;
          end else begin
            state_nxt = S_ADDV;
            code_nxt  = ST_ZERO;
          end
        end
      end
      S_NSQ:    if (sts.sq_done) state_nxt = S_DLOAD;
      S_DLOAD:  state_nxt = S_DIV;
      S_DIV:    if (sts.div_done) state_nxt = S_SLOAD;
      S_SLOAD:  state_nxt = S_SQRT;
      S_SQRT:   if (sts.sqrt_done) state_nxt = S_NSTORE;
      S_NSTORE: begin
        if (!sts.comp_last) begin
          state_nxt = S_DLOAD;
        end else begin
          code_nxt  = ST_OK;
          state_nxt = sts.is_query ? S_FIN : S_ADDV;
        end
      end
      S_ADDV:   state_nxt = S_ACC_RD;
      S_ACC_RD: begin
        if (sts.cur_fnd) begin
          state_nxt = S_ACC_WR;
        end else if (sts.vtx_last) begin
          state_nxt = S_FIN;
        end
      end
      S_ACC_WR: state_nxt = sts.vtx_last ? S_FIN : S_ACC_RD;
      S_Q_RD:   state_nxt = S_Q_WR;
      S_Q_WR:   state_nxt = S_NINIT;
      S_FIN:    if (sts.out_room) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.code = code_r;
    in_stall = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE:   cmd.load    = in_valid;
      S_SCAN:   cmd.scan    = 1'b1;
      S_CHECK:  cmd.cnt_clr = 1'b1;
      S_XP:     cmd.xp      = 1'b1;
      S_NINIT:  cmd.ninit   = 1'b1;
      S_NSHIFT: begin
        cmd.shift   = 1'b1;
        cmd.cnt_clr = 1'b1;
      end
      S_NSQ:    cmd.sq      = 1'b1;
      S_DLOAD: begin
        cmd.dload   = 1'b1;
        cmd.cnt_clr = 1'b1;
      end
      S_DIV:    cmd.div     = 1'b1;
      S_SLOAD: begin
        cmd.sload   = 1'b1;
        cmd.cnt_clr = 1'b1;
      end
      S_SQRT:   cmd.sqrt    = 1'b1;
      S_NSTORE: cmd.nstore  = 1'b1;
      S_ADDV:   cmd.addv    = 1'b1;
      S_ACC_RD: cmd.acc_rd  = 1'b1;
      S_ACC_WR: cmd.acc_wr  = 1'b1;
      S_Q_RD:   cmd.cnt_clr = 1'b1;
      S_Q_WR:   cmd.q_wr    = 1'b1;
      S_FIN:    cmd.res_ld  = sts.out_room;
      default:  cmd.cnt_clr = 1'b1;
    endcase
  end

endmodule

// ===== design/svna_dp.sv =====
// ----------------------------------------------------------------------------
// svna_dp: datapath
// Item registers, table search, shared multiplier, restoring divider,
// bit-pair square root, accumulator update and result register.
// ----------------------------------------------------------------------------
module svna_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_func,
  input  logic signed [svna_pkg::CRD_W-1:0] in_ax,
  input  logic signed [svna_pkg::CRD_W-1:0] in_ay,
  input  logic signed [svna_pkg::CRD_W-1:0] in_az,
  input  logic signed [svna_pkg::CRD_W-1:0] in_bx,
  input  logic signed [svna_pkg::CRD_W-1:0] in_by,
  input  logic signed [svna_pkg::CRD_W-1:0] in_bz,
  input  logic signed [svna_pkg::CRD_W-1:0] in_cx,
  input  logic signed [svna_pkg::CRD_W-1:0] in_cy,
  input  logic signed [svna_pkg::CRD_W-1:0] in_cz,
  input  logic                              cfg_we,
  input  logic                              cfg_wdata,
  input  svna_pkg::cmd_t                    cmd,
  output svna_pkg::sts_t                    sts,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [svna_pkg::NRM_W-1:0] out_nx,
  output logic signed [svna_pkg::NRM_W-1:0] out_ny,
  output logic signed [svna_pkg::NRM_W-1:0] out_nz,
  output logic [1:0]                        out_status
);

  import svna_pkg::*;

  localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
    if (s[SUM_W] != s[SUM_W-1]) begin
      return s[SUM_W] ? SUM_MIN : SUM_MAX;
    end
    return s[SUM_W-1:0];
  endfunction

  // item
  logic                    func_r;
  logic signed [CRD_W-1:0] a_r [3];
  logic signed [CRD_W-1:0] b_r [3];
  logic signed [CRD_W-1:0] c_r [3];
  logic                    wm_r;
  logic [KEY_W-1:0]        keys [3];
  logic signed [CRD_W:0]   e1 [3];
  logic signed [CRD_W:0]   e2 [3];

  // table search
  logic [CW-1:0]    used_r;
  logic [CW-1:0]    sa_r;
  logic             cmpv_r;
  logic [AW-1:0]    cmpi_r;
  logic             fnd_r [3];
  logic [AW-1:0]    fidx_r [3];
  logic [1:0]       needed;
  logic [CW:0]      need_tot;

  // arithmetic
  logic [CNT_W-1:0]        cnt_r;
  logic signed [17:0]      mul_a, mul_b;
  logic signed [35:0]      prod_r;
  logic [SUM_W-1:0]        prod_ext;
  logic [2:0]              pj;
  logic [SUM_W-1:0]        v_r [3];
  logic [SUM_W-1:0]        mag_r [3];
  logic [SQ_W-1:0]         sq_r [3];
  logic [S_W-1:0]          s_r;
  logic [1:0]              comp_r;
  logic [1:0]              vtx_r;
  logic [S_W-1:0]          rem_r;
  logic [DQ_W-1:0]         dq_r;
  logic [S_W:0]            trial;
  logic                    ge;
  logic [OP_W-1:0]         op_r, res_r, one_r;
  logic [OP_W-1:0]         sq_t;
  logic signed [NRM_W-1:0] n_r [3];
  logic [SUM_W-1:0]        add_r [3];
  logic                    big, zero;

  // memories
  logic                 pos_we;
  logic [KEY_W-1:0]     pos_rdata;
  logic                 sum_we;
  logic [AW-1:0]        sum_waddr;
  logic [3*SUM_W-1:0]   sum_wdata, sum_rdata;
  logic [SUM_W-1:0]     rd_sum [3];
  logic [SUM_W-1:0]     upd_sum [3];

  // result
  logic                    out_valid_r;
  logic signed [NRM_W-1:0] out_n_r [3];
  status_t                 out_status_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e1[i] = {b_r[i][CRD_W-1], b_r[i]} - {a_r[i][CRD_W-1], a_r[i]};
      e2[i] = {c_r[i][CRD_W-1], c_r[i]} - {a_r[i][CRD_W-1], a_r[i]};
    end
    keys[0] = {a_r[2], a_r[1], a_r[0]};
    keys[1] = {b_r[2], b_r[1], b_r[0]};
    keys[2] = {c_r[2], c_r[1], c_r[0]};
  end

  // new entries this triangle would take; repeated keys count once
  always_comb begin
    needed = 2'd0;
    if (!fnd_r[0]) needed = needed + 2'd1;
    if (!fnd_r[1] && keys[1] != keys[0]) needed = needed + 2'd1;
    if (!fnd_r[2] && keys[2] != keys[0] && keys[2] != keys[1]) needed = needed + 2'd1;
    need_tot = {1'b0, used_r} + {{(CW-1){1'b0}}, needed};
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd.sq) begin
      if (cnt_r < SQ_LAST) begin
        mul_a = {1'b0, mag_r[cnt_r[1:0]][R_W-1:0]};
        mul_b = {1'b0, mag_r[cnt_r[1:0]][R_W-1:0]};
      end
    end else begin
      unique case (cnt_r[2:0])
        3'd0:    begin mul_a = 18'(e1[1]); mul_b = 18'(e2[2]); end
        3'd1:    begin mul_a = 18'(e1[2]); mul_b = 18'(e2[1]); end
        3'd2:    begin mul_a = 18'(e1[2]); mul_b = 18'(e2[0]); end
        3'd3:    begin mul_a = 18'(e1[0]); mul_b = 18'(e2[2]); end
        3'd4:    begin mul_a = 18'(e1[0]); mul_b = 18'(e2[1]); end
        3'd5:    begin mul_a = 18'(e1[1]); mul_b = 18'(e2[0]); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  always_comb begin
    prod_ext = {{(SUM_W-36){prod_r[35]}}, prod_r};
    pj       = cnt_r[2:0] - 3'd1;
    big      = 1'b0;
    zero     = 1'b1;
    for (int i = 0; i < 3; i++) begin
      big  = big | (|mag_r[i][SUM_W-1:R_W]);
      zero = zero & (mag_r[i] == '0);
    end
    trial = {rem_r, dq_r[DQ_W-1]};
    ge    = (trial >= {1'b0, s_r});
    sq_t  = res_r + one_r;
    for (int i = 0; i < 3; i++) begin
      rd_sum[i]  = sum_rdata[i*SUM_W +: SUM_W];
      upd_sum[i] = sat_add(rd_sum[i], add_r[i]);
    end
  end

  // table write side
  always_comb begin
    pos_we    = cmd.acc_rd && !fnd_r[vtx_r];
    sum_we    = cmd.acc_wr || pos_we;
    sum_waddr = cmd.acc_wr ? fidx_r[vtx_r] : used_r[AW-1:0];
    sum_wdata = cmd.acc_wr ? {upd_sum[2], upd_sum[1], upd_sum[0]}
                           : {add_r[2], add_r[1], add_r[0]};
  end

  svna_ram #(.W(KEY_W), .D(TABLE_ENTRIES)) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (used_r[AW-1:0]),
    .wdata (keys[vtx_r]),
    .raddr (sa_r[AW-1:0]),
    .rdata (pos_rdata)
  );

  svna_ram #(.W(3*SUM_W), .D(TABLE_ENTRIES)) u_sum_ram (
    .clk   (clk),
    .we    (sum_we),
    .waddr (sum_waddr),
    .wdata (sum_wdata),
    .raddr (fidx_r[vtx_r]),
    .rdata (sum_rdata)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wm_r        <= 1'b0;
      used_r      <= '0;
      cmpv_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) wm_r <= cfg_wdata;
      if (pos_we) used_r <= used_r + 1'b1;
      if (cmd.load) begin
        cmpv_r <= 1'b0;
      end else if (cmd.scan) begin
        cmpv_r <= (sa_r < used_r);
      end
      if (cmd.res_ld) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;

    if (cmd.load) begin
      func_r <= in_func;
      a_r[0] <= in_ax; a_r[1] <= in_ay; a_r[2] <= in_az;
      b_r[0] <= in_bx; b_r[1] <= in_by; b_r[2] <= in_bz;
      c_r[0] <= in_cx; c_r[1] <= in_cy; c_r[2] <= in_cz;
      sa_r   <= '0;
      vtx_r  <= 2'd0;
      for (int i = 0; i < 3; i++) fnd_r[i] <= 1'b0;
    end

    // search: read one entry a cycle, compare it in the next cycle
    if (cmd.scan) begin
      if (sa_r < used_r) begin
        sa_r   <= sa_r + 1'b1;
        cmpi_r <= sa_r[AW-1:0];
      end
      if (cmpv_r) begin
        for (int i = 0; i < 3; i++) begin
          if (pos_rdata == keys[i]) begin
            fnd_r[i]  <= 1'b1;
            fidx_r[i] <= cmpi_r;
          end
        end
      end
    end

    if (cmd.cnt_clr) begin
      cnt_r <= '0;
    end else if (cmd.xp || cmd.sq || cmd.div || cmd.sqrt) begin
      cnt_r <= cnt_r + 1'b1;
    end

    // cross product: even product sets, odd product subtracts
    if (cmd.xp && cnt_r != '0) begin
      if (!pj[0]) begin
        v_r[pj[2:1]] <= prod_ext;
      end else begin
        v_r[pj[2:1]] <= v_r[pj[2:1]] - prod_ext;
      end
    end

    if (cmd.q_wr) begin
      for (int i = 0; i < 3; i++) v_r[i] <= rd_sum[i];
    end

    if (cmd.ninit) begin
      comp_r <= 2'd0;
      for (int i = 0; i < 3; i++) begin
        mag_r[i] <= v_r[i][SUM_W-1] ? (~v_r[i] + 1'b1) : v_r[i];
      end
    end

    if (cmd.shift && big) begin
      for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] >> 1;
    end

    if (cmd.sq) begin
      if (cnt_r == '0) begin
        s_r <= '0;
      end else begin
        sq_r[pj[1:0]] <= prod_r[SQ_W-1:0];
        s_r           <= s_r + {{(S_W-SQ_W){1'b0}}, prod_r[SQ_W-1:0]};
      end
    end

    if (cmd.dload) begin
      rem_r <= '0;
      dq_r  <= {sq_r[comp_r], {(DQ_W-SQ_W){1'b0}}};
    end

    if (cmd.div) begin
      rem_r <= ge ? S_W'(trial - {1'b0, s_r}) : trial[S_W-1:0];
      dq_r  <= {dq_r[DQ_W-2:0], ge};
    end

    if (cmd.sload) begin
      op_r  <= dq_r[OP_W-1:0];
      res_r <= '0;
      one_r <= OP_W'(1) << (OP_W - 2);
    end

    if (cmd.sqrt) begin
      if (op_r >= sq_t) begin
        op_r  <= op_r - sq_t;
        res_r <= (res_r >> 1) + one_r;
      end else begin
        res_r <= res_r >> 1;
      end
      one_r <= one_r >> 2;
    end

    if (cmd.nstore) begin
      n_r[comp_r] <= v_r[comp_r][SUM_W-1] ? NRM_W'(0 - res_r[NRM_W-1:0])
                                          : res_r[NRM_W-1:0];
      comp_r      <= comp_r + 2'd1;
    end

    if (cmd.addv) begin
      vtx_r <= 2'd0;
      for (int i = 0; i < 3; i++) begin
        if (cmd.code != ST_OK) begin
          add_r[i] <= '0;
        end else if (wm_r) begin
          add_r[i] <= {{(SUM_W-NRM_W-1){n_r[i][NRM_W-1]}}, n_r[i], 1'b0};
        end else begin
          add_r[i] <= v_r[i];
        end
      end
    end

    // a new entry also resolves later vertices at the same position
    if (pos_we) begin
      for (int j = 0; j < 3; j++) begin
        if (j >= vtx_r && keys[j] == keys[vtx_r]) begin
          fnd_r[j]  <= 1'b1;
          fidx_r[j] <= used_r[AW-1:0];
        end
      end
    end

    if (pos_we || cmd.acc_wr) begin
      vtx_r <= (vtx_r == 2'd2) ? 2'd0 : vtx_r + 2'd1;
    end

    if (cmd.res_ld) begin
      out_status_r <= cmd.code;
      for (int i = 0; i < 3; i++) begin
        out_n_r[i] <= (cmd.code == ST_OK) ? n_r[i] : '0;
      end
    end
  end

  always_comb begin
    sts.scan_done = !(sa_r < used_r) && !cmpv_r;
    sts.is_query  = (func_r == FN_QUERY);
    sts.fnd0      = fnd_r[0];
    sts.full      = need_tot > (CW+1)'(TABLE_ENTRIES);
    sts.xp_done   = (cnt_r == XP_LAST);
    sts.big       = big;
    sts.zero      = zero;
    sts.sq_done   = (cnt_r == SQ_LAST);
    sts.div_done  = (cnt_r == DIV_LAST);
    sts.sqrt_done = (cnt_r == SQRT_LAST);
    sts.comp_last = (comp_r == 2'd2);
    sts.cur_fnd   = fnd_r[vtx_r];
    sts.vtx_last  = (vtx_r == 2'd2);
    sts.out_room  = !out_valid_r || !out_stall;
  end

  assign out_valid  = out_valid_r;
  assign out_nx     = out_n_r[0];
  assign out_ny     = out_n_r[1];
  assign out_nz     = out_n_r[2];
  assign out_status = out_status_r;

endmodule

// ===== design/smooth_vertex_normal_accumulator_core.sv =====
// ----------------------------------------------------------------------------
// smooth_vertex_normal_accumulator_core: per-position normal accumulator
// Adds face normals of triangles into a position-keyed table and returns
// flat or smoothed unit normals.
// ----------------------------------------------------------------------------
// Throughput: one item at a time; the next transfer is taken as soon as the
//   result sits in the output register, even while that result is stalled.
// Reset: synchronous, active low; empties table, clears weight_mode, result valid.
// ----------------------------------------------------------------------------
// Flow per item:
//   search  - position RAM swept 0..U-1, one read per cycle, compare in the next
//             cycle against all three vertex keys.
//   check   - query: unknown position ends here; add: not enough free
//             entries ends here with no state change.
//   cross   - six products through one 18x18 multiplier.
//   normal  - common shift until every magnitude fits 17 bits, squares and
//             their sum through the same multiplier, then per component a
//             62-step restoring divide of r*r*2^28 by the sum and a 15-step
//             square root of the quotient.
//   update  - per vertex: allocate a new entry or read-modify-write the
//             saturating sums.
// Controller and datapath are separate; they talk only through the cmd and
// sts bundles.
// ----------------------------------------------------------------------------
module smooth_vertex_normal_accumulator_core (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_func,
  input  logic signed [svna_pkg::CRD_W-1:0] in_ax,
  input  logic signed [svna_pkg::CRD_W-1:0] in_ay,
  input  logic signed [svna_pkg::CRD_W-1:0] in_az,
  input  logic signed [svna_pkg::CRD_W-1:0] in_bx,
  input  logic signed [svna_pkg::CRD_W-1:0] in_by,
  input  logic signed [svna_pkg::CRD_W-1:0] in_bz,
  input  logic signed [svna_pkg::CRD_W-1:0] in_cx,
  input  logic signed [svna_pkg::CRD_W-1:0] in_cy,
  input  logic signed [svna_pkg::CRD_W-1:0] in_cz,
  // weight_mode register
  input  logic                              cfg_we,
  input  logic                              cfg_wdata,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [svna_pkg::NRM_W-1:0] out_nx,
  output logic signed [svna_pkg::NRM_W-1:0] out_ny,
  output logic signed [svna_pkg::NRM_W-1:0] out_nz,
  output logic [1:0]                        out_status
);

  import svna_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: one item in flight, in_stall high from transfer to result load
  svna_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath owns the two table RAMs and the result register
  svna_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_func    (in_func),
    .in_ax      (in_ax),
    .in_ay      (in_ay),
    .in_az      (in_az),
    .in_bx      (in_bx),
    .in_by      (in_by),
    .in_bz      (in_bz),
    .in_cx      (in_cx),
    .in_cy      (in_cy),
    .in_cz      (in_cz),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_nx     (out_nx),
    .out_ny     (out_ny),
    .out_nz     (out_nz),
    .out_status (out_status)
  );

endmodule

// ===== design/svna_chk.sv =====
// ----------------------------------------------------------------------------
// svna_chk: port-level checks
// Observes the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
module svna_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [svna_pkg::NRM_W-1:0] out_nx,
  input logic signed [svna_pkg::NRM_W-1:0] out_ny,
  input logic signed [svna_pkg::NRM_W-1:0] out_nz,
  input logic [1:0]                        out_status
);

  import svna_pkg::*;

  // reset leaves no result pending
  a_rst_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // one item at a time: a transfer closes the input until its result is loaded
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input open straight after a transfer");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_nx) && $stable(out_ny)
                                  && $stable(out_nz) && $stable(out_status)))
    else $error("stalled result changed");

  // any failure status carries a zero vector
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_nx == '0 && out_ny == '0 && out_nz == '0))
    else $error("non-zero normal with failure status");

  // components of a good result stay within one
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_OK) |->
      (out_nx <= 16'sd16384 && out_nx >= -16'sd16384 &&
       out_ny <= 16'sd16384 && out_ny >= -16'sd16384 &&
       out_nz <= 16'sd16384 && out_nz >= -16'sd16384))
    else $error("normal component out of range");

endmodule

bind smooth_vertex_normal_accumulator_core svna_chk u_svna_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_nx     (out_nx),
  .out_ny     (out_ny),
  .out_nz     (out_nz),
  .out_status (out_status)
);
